### hdl/swirl_warp_address_generator_top_assert.svh
// assertion macros for the swirl warp address generator
// used by the port checker; needs clk and rst in scope
`ifndef SWIRL_WARP_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`define SWIRL_WARP_ADDRESS_GENERATOR_TOP_ASSERT_SVH
// checked only out of reset
`define SWG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checked during reset as well
`define SWG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### hdl/swg_pkg.sv
// shared constants, types and tables for the swirl warp address generator
// no dependencies
package swg_pkg;

  localparam int SQRT_STEPS   = 20;
  localparam int CORDIC_STEPS = 16;

  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_INV_REACH   = 3'd2;
  localparam logic [2:0] REG_TWIST_TOTAL = 3'd3;
  localparam logic [2:0] REG_X_SCALE     = 3'd4;
  localparam logic [2:0] REG_Y_SCALE     = 3'd5;
  localparam logic [2:0] REG_SRC_WIDTH   = 3'd6;
  localparam logic [2:0] REG_SRC_HEIGHT  = 3'd7;

  localparam logic [16:0] LOG2E_Q16   = 17'd94548;
  localparam logic [7:0]  FALL_MIN    = 8'd196;
  localparam logic [19:0] TWO_PI_Q16  = 20'd411775;
  localparam logic [19:0] FOUR_PI_Q16 = 20'd823550;
  localparam logic signed [19:0] PI_Q16      = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [17:0] GAIN_INV    = 18'sd39797;
  localparam logic [12:0] SRC_LIMIT = 13'd4096;

  typedef struct packed {
    logic [10:0] x;
    logic [10:0] y;
    logic signed [19:0] dx;
    logic signed [19:0] dy;
  } pay_t;

  function automatic logic [16:0] exp2_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:  v = 17'd65536;
      5'd1:  v = 17'd62757;
      5'd2:  v = 17'd60097;
      5'd3:  v = 17'd57549;
      5'd4:  v = 17'd55109;
      5'd5:  v = 17'd52773;
      5'd6:  v = 17'd50535;
      5'd7:  v = 17'd48392;
      5'd8:  v = 17'd46341;
      5'd9:  v = 17'd44377;
      5'd10: v = 17'd42495;
      5'd11: v = 17'd40692;
      5'd12: v = 17'd38968;
      5'd13: v = 17'd37317;
      5'd14: v = 17'd35734;
      5'd15: v = 17'd34218;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  function automatic logic signed [19:0] atan_tab(input int i);
    logic signed [19:0] v;
    case (i)
      0:  v = 20'sd51472;
      1:  v = 20'sd30385;
      2:  v = 20'sd16055;
      3:  v = 20'sd8150;
      4:  v = 20'sd4091;
      5:  v = 20'sd2047;
      6:  v = 20'sd1024;
      7:  v = 20'sd512;
      8:  v = 20'sd256;
      9:  v = 20'sd128;
      10: v = 20'sd64;
      11: v = 20'sd32;
      12: v = 20'sd16;
      13: v = 20'sd8;
      14: v = 20'sd4;
      default: v = 20'sd2;
    endcase
    return v;
  endfunction

  // scaled index clamped to [0, limit - 1]
  function automatic logic [11:0] clamp_idx(input logic signed [27:0] v,
                                            input logic [12:0] size);
    logic [12:0] lim;
    logic [11:0] r;
    lim = (size == 13'd0) ? 13'd1 : ((size > SRC_LIMIT) ? SRC_LIMIT : size);
    if (v < 0) begin
      r = 12'd0;
    end else if (v > 28'(lim - 13'd1)) begin
      r = 12'(lim - 13'd1);
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

endpackage

### hdl/swirl_warp_address_generator_top.sv
// throughput: one beat per cycle; the whole pipe holds while an output beat waits
// stages: offset, squares, sum, 20 square-root digits, falloff (4), angle (3),
//   16 cordic rotations, gain, offset add, scale partial products, clamp
// reset (rst, synchronous, active high) clears all valid bits and loads the
//   register defaults; configuration writes are taken every cycle
module swirl_warp_address_generator_top import swg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // dest_x [10:0], dest_y [21:11], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // src_x [11:0], src_y [23:12]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // configuration registers
  logic [18:0] center_x, center_y;
  logic [19:0] inv_reach;
  logic [15:0] twist_total;
  logic [23:0] x_scale, y_scale;
  logic [12:0] src_width, src_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      inv_reach   <= 20'd65536;
      twist_total <= '0;
      x_scale     <= 24'd65536;
      y_scale     <= 24'd65536;
      src_width   <= 13'd1;
      src_height  <= 13'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X:    center_x    <= cfg_data[18:0];
        REG_CENTER_Y:    center_y    <= cfg_data[18:0];
        REG_INV_REACH:   inv_reach   <= cfg_data[19:0];
        REG_TWIST_TOTAL: twist_total <= cfg_data[15:0];
        REG_X_SCALE:     x_scale     <= cfg_data;
        REG_Y_SCALE:     y_scale     <= cfg_data;
        REG_SRC_WIDTH:   src_width   <= cfg_data[12:0];
        REG_SRC_HEIGHT:  src_height  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // one enable for every stage: move when the output register is free or taken
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage a: offset from the centre in Q.8
  logic a_v;
  pay_t a_p;
  logic [10:0] in_x, in_y;
  assign in_x = s_tdata[10:0];
  assign in_y = s_tdata[21:11];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p.x  <= in_x;
      a_p.y  <= in_y;
      a_p.dx <= 20'($signed({1'b0, in_x, 8'b0}) - $signed({1'b0, center_x}));
      a_p.dy <= 20'($signed({1'b0, in_y, 8'b0}) - $signed({1'b0, center_y}));
    end
  end

  // stage b: squares, stage c: sum of squares
  logic b_v, c_v;
  pay_t b_p, c_p;
  logic [39:0] b_sx2, b_sy2, c_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_p   <= a_p;
      b_sx2 <= 40'(a_p.dx * a_p.dx);
      b_sy2 <= 40'(a_p.dy * a_p.dy);
      c_p   <= b_p;
      c_n   <= b_sx2 + b_sy2;
    end
  end

  // square root, one result digit per stage
  logic        q_v    [SQRT_STEPS+1];
  pay_t        q_p    [SQRT_STEPS+1];
  logic [39:0] q_n    [SQRT_STEPS+1];
  logic [20:0] q_rem  [SQRT_STEPS+1];
  logic [19:0] q_root [SQRT_STEPS+1];

  assign q_v[0]    = c_v;
  assign q_p[0]    = c_p;
  assign q_n[0]    = c_n;
  assign q_rem[0]  = '0;
  assign q_root[0] = '0;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [22:0] rem_sh, trial;
    logic        take;
    assign rem_sh = {q_rem[j], q_n[j][39:38]};
    assign trial  = {1'b0, q_root[j], 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        q_v[j+1] <= 1'b0;
      end else if (en) begin
        q_v[j+1] <= q_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_p[j+1]    <= q_p[j];
        q_n[j+1]    <= {q_n[j][37:0], 2'b00};
        q_rem[j+1]  <= take ? 21'(rem_sh - trial) : rem_sh[20:0];
        q_root[j+1] <= {q_root[j][18:0], take};
      end
    end
  end

  // falloff: d scaled radius, e times log2(e), f table lookup, g interpolate
  logic        d_v, e_v, f_v, g_v;
  pay_t        d_p, e_p, f_p, g_p;
  logic [31:0] d_t;
  logic [32:0] e_u;
  logic [16:0] f_base;
  logic [23:0] f_prod;
  logic [4:0]  f_k;
  logic        f_zero;
  logic [16:0] g_fall;
  logic [4:0]  e_idx;
  logic [16:0] e_d0, e_d1;
  logic [16:0] f_lin;

  assign e_idx = {1'b0, e_u[15:12]};
  assign e_d0  = exp2_tab(e_idx);
  assign e_d1  = exp2_tab(e_idx + 5'd1);
  assign f_lin = f_base - 17'(f_prod >> 12);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
    end else if (en) begin
      d_v <= q_v[SQRT_STEPS];
      e_v <= d_v;
      f_v <= e_v;
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_p    <= q_p[SQRT_STEPS];
      d_t    <= 32'((40'(q_root[SQRT_STEPS]) * 40'(inv_reach)) >> 8);
      e_p    <= d_p;
      e_u    <= 33'((49'(d_t) * 49'(LOG2E_Q16)) >> 16);
      f_p    <= e_p;
      f_base <= e_d0;
      f_prod <= 24'(12'(e_d0 - e_d1) * e_u[11:0]);
      f_zero <= (e_u[32:16] >= 17'd17);
      f_k    <= e_u[20:16];
      g_p    <= f_p;
      g_fall <= f_zero ? 17'd0 : (f_lin >> f_k);
    end
  end

  // angle: h raw product, i wrap to [0, 2pi), j fold into [-pi/2, pi/2]
  logic        h_v, i_v, j_v;
  pay_t        h_p, i_p, j_p;
  logic [20:0] h_z;
  logic        h_rot, i_rot, j_rot;
  logic [18:0] i_z;
  logic signed [19:0] i_zs;
  logic signed [19:0] j_z;
  logic signed [31:0] j_vx, j_vy;
  logic signed [31:0] i_vx, i_vy;

  assign i_zs = (i_z > 19'(PI_Q16)) ? 20'(20'($signed({1'b0, i_z})) - $signed(TWO_PI_Q16))
                                    : $signed({1'b0, i_z});
  assign i_vx = 32'(i_p.dx) <<< 8;
  assign i_vy = 32'(i_p.dy) <<< 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
      i_v <= 1'b0;
      j_v <= 1'b0;
    end else if (en) begin
      h_v <= g_v;
      i_v <= h_v;
      j_v <= i_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_p   <= g_p;
      h_z   <= 21'((33'(twist_total) * 33'(g_fall)) >> 12);
      h_rot <= (g_fall > 17'(FALL_MIN));
      i_p   <= h_p;
      i_rot <= h_rot;
      if (h_z >= 21'(FOUR_PI_Q16)) begin
        i_z <= 19'(h_z - 21'(FOUR_PI_Q16));
      end else if (h_z >= 21'(TWO_PI_Q16)) begin
        i_z <= 19'(h_z - 21'(TWO_PI_Q16));
      end else begin
        i_z <= h_z[18:0];
      end
      j_p   <= i_p;
      j_rot <= i_rot;
      if (i_zs > HALF_PI_Q16) begin
        j_vx <= -i_vx;
        j_vy <= -i_vy;
        j_z  <= i_zs - PI_Q16;
      end else if (i_zs < -HALF_PI_Q16) begin
        j_vx <= -i_vx;
        j_vy <= -i_vy;
        j_z  <= i_zs + PI_Q16;
      end else begin
        j_vx <= i_vx;
        j_vy <= i_vy;
        j_z  <= i_zs;
      end
    end
  end

  // cordic rotation, one micro-rotation per stage
  logic               k_v   [CORDIC_STEPS+1];
  pay_t               k_p   [CORDIC_STEPS+1];
  logic               k_rot [CORDIC_STEPS+1];
  logic signed [31:0] k_vx  [CORDIC_STEPS+1];
  logic signed [31:0] k_vy  [CORDIC_STEPS+1];
  logic signed [19:0] k_z   [CORDIC_STEPS+1];

  assign k_v[0]   = j_v;
  assign k_p[0]   = j_p;
  assign k_rot[0] = j_rot;
  assign k_vx[0]  = j_vx;
  assign k_vy[0]  = j_vy;
  assign k_z[0]   = j_z;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [31:0] sx, sy;
    assign sx = k_vx[i] >>> i;
    assign sy = k_vy[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        k_v[i+1] <= 1'b0;
      end else if (en) begin
        k_v[i+1] <= k_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        k_p[i+1]   <= k_p[i];
        k_rot[i+1] <= k_rot[i];
        if (k_z[i] >= 0) begin
          k_vx[i+1] <= k_vx[i] - sy;
          k_vy[i+1] <= k_vy[i] + sx;
          k_z[i+1]  <= k_z[i] - atan_tab(i);
        end else begin
          k_vx[i+1] <= k_vx[i] + sy;
          k_vy[i+1] <= k_vy[i] - sx;
          k_z[i+1]  <= k_z[i] + atan_tab(i);
        end
      end
    end
  end

  // l gain correction, m source point, n scale partial products, o clamp
  logic               l_v, m_v, n_v;
  pay_t               l_p;
  logic               l_rot;
  logic signed [31:0] l_gx, l_gy;
  logic signed [49:0] gain_x, gain_y;
  logic signed [33:0] m_px, m_py;
  logic signed [46:0] n_xlo, n_xhi, n_ylo, n_yhi;
  logic signed [59:0] o_sx, o_sy;
  logic signed [27:0] o_ix, o_iy;

  assign gain_x = k_vx[CORDIC_STEPS] * GAIN_INV;
  assign gain_y = k_vy[CORDIC_STEPS] * GAIN_INV;
  assign o_sx   = (60'(n_xhi) <<< 12) + 60'(n_xlo);
  assign o_sy   = (60'(n_yhi) <<< 12) + 60'(n_ylo);
  assign o_ix   = 28'(o_sx >>> 32);
  assign o_iy   = 28'(o_sy >>> 32);

  always_ff @(posedge clk) begin
    if (rst) begin
      l_v      <= 1'b0;
      m_v      <= 1'b0;
      n_v      <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      l_v      <= k_v[CORDIC_STEPS];
      m_v      <= l_v;
      n_v      <= m_v;
      m_tvalid <= n_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_p   <= k_p[CORDIC_STEPS];
      l_rot <= k_rot[CORDIC_STEPS];
      l_gx  <= 32'(gain_x >>> 16);
      l_gy  <= 32'(gain_y >>> 16);
      if (l_rot) begin
        m_px <= 34'($signed({1'b0, center_x, 8'b0})) + 34'(l_gx);
        m_py <= 34'($signed({1'b0, center_y, 8'b0})) + 34'(l_gy);
      end else begin
        m_px <= $signed(34'({l_p.x, 16'b0}));
        m_py <= $signed(34'({l_p.y, 16'b0}));
      end
      n_xlo <= m_px * $signed({1'b0, x_scale[11:0]});
      n_xhi <= m_px * $signed({1'b0, x_scale[23:12]});
      n_ylo <= m_py * $signed({1'b0, y_scale[11:0]});
      n_yhi <= m_py * $signed({1'b0, y_scale[23:12]});
      m_tdata <= {clamp_idx(o_iy, src_height), clamp_idx(o_ix, src_width)};
    end
  end

endmodule

### hdl/swg_checker.sv
// port checker for the swirl warp address generator, bound to the top level
// depends on swirl_warp_address_generator_top_assert.svh
`include "swirl_warp_address_generator_top_assert.svh"
module swg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        cfg_ready
);

  // no output beat right after reset
  `SWG_ASSERT_RST(a_rst_empty, rst |=> !m_tvalid, "output valid after reset")
  // a held output beat keeps its data
  `SWG_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "beat lost")
  // input is only held off while an output beat waits
  `SWG_ASSERT(a_backpressure, !s_tready |-> m_tvalid && !m_tready, "needless stall")
  // a waiting output beat blocks new input but not configuration writes
  `SWG_ASSERT(a_full, m_tvalid && !m_tready |-> !s_tready && cfg_ready, "input taken")

endmodule

bind swirl_warp_address_generator_top swg_checker u_swg_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .cfg_ready(cfg_ready)
);
